// ----- rtl/smx_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package smx_pkg;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_UNIT
	} state_t;

	typedef struct packed {
		logic start;
		logic is_mul;
		logic is_mod;
	} md_req_t;

	localparam logic [7:0] OP_HALT  = 8'd0;
	localparam logic [7:0] OP_PUSH  = 8'd1;
	localparam logic [7:0] OP_POP   = 8'd2;
	localparam logic [7:0] OP_DUP   = 8'd3;
	localparam logic [7:0] OP_SWAP  = 8'd4;
	localparam logic [7:0] OP_ADD   = 8'd5;
	localparam logic [7:0] OP_SUB   = 8'd6;
	localparam logic [7:0] OP_MUL   = 8'd7;
	localparam logic [7:0] OP_DIV   = 8'd8;
	localparam logic [7:0] OP_MOD   = 8'd9;
	localparam logic [7:0] OP_NEG   = 8'd10;
	localparam logic [7:0] OP_AND   = 8'd11;
	localparam logic [7:0] OP_OR    = 8'd12;
	localparam logic [7:0] OP_XOR   = 8'd13;
	localparam logic [7:0] OP_NOT   = 8'd14;
	localparam logic [7:0] OP_SHL   = 8'd15;
	localparam logic [7:0] OP_SHR   = 8'd16;
	localparam logic [7:0] OP_EQ    = 8'd17;
	localparam logic [7:0] OP_NE    = 8'd18;
	localparam logic [7:0] OP_LT    = 8'd19;
	localparam logic [7:0] OP_LE    = 8'd20;
	localparam logic [7:0] OP_GT    = 8'd21;
	localparam logic [7:0] OP_GE    = 8'd22;
	localparam logic [7:0] OP_JMP   = 8'd23;
	localparam logic [7:0] OP_JZ    = 8'd24;
	localparam logic [7:0] OP_JNZ   = 8'd25;
	localparam logic [7:0] OP_LOAD  = 8'd26;
	localparam logic [7:0] OP_SAVE  = 8'd27;
	localparam logic [7:0] OP_EMIT  = 8'd28;
	localparam logic [7:0] OP_INC   = 8'd29;
	localparam logic [7:0] OP_DEC   = 8'd30;
	localparam logic [7:0] OP_ROT   = 8'd31;
	localparam logic [7:0] OP_OVER  = 8'd32;
	localparam logic [7:0] OP_NOP   = 8'd33;
	localparam logic [7:0] OP_CALL  = 8'd34;
	localparam logic [7:0] OP_RET   = 8'd35;
	localparam logic [7:0] OP_CLR   = 8'd36;
	localparam logic [7:0] OP_DROP  = 8'd37;
	localparam logic [7:0] OP_CMP   = 8'd38;
	localparam logic [7:0] OP_ABS   = 8'd39;

	localparam logic [2:0] ST_RUN  = 3'd0;
	localparam logic [2:0] ST_HALT = 3'd1;
	localparam logic [2:0] ST_END  = 3'd2;
	localparam logic [2:0] ST_WDOG = 3'd3;
	localparam logic [2:0] ST_BAD  = 3'd4;
	localparam logic [2:0] ST_OVF  = 3'd5;

	localparam logic [8:0]  PL_RESET  = 9'd256;
	localparam logic [19:0] LIM_RESET = 20'd1000000;

	localparam logic CFG_PL  = 1'b0;
	localparam logic CFG_LIM = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/smx_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none

module smx_alu (
	input  wire logic [7:0]  op,
	input  wire logic [63:0] a,
	input  wire logic [63:0] b,
	output logic      [63:0] y
);
	import smx_pkg::*;

	logic a_lt_b;
	logic b_lt_a;

	assign a_lt_b = $signed(a) < $signed(b);
	assign b_lt_a = $signed(b) < $signed(a);

	always_comb begin
		case (op)
			OP_ADD: y = a + b;
			OP_SUB: y = a - b;
			OP_AND: y = a & b;
			OP_OR:  y = a | b;
			OP_XOR: y = a ^ b;
			OP_SHL: y = a << b[5:0];
			OP_SHR: y = 64'($signed(a) >>> b[5:0]);
			OP_EQ:  y = {63'd0, a == b};
			OP_NE:  y = {63'd0, a != b};
			OP_LT:  y = {63'd0, a_lt_b};
			OP_LE:  y = {63'd0, !b_lt_a};
			OP_GT:  y = {63'd0, b_lt_a};
			OP_GE:  y = {63'd0, !a_lt_b};
			OP_CMP: y = b_lt_a ? 64'd1 : (a_lt_b ? '1 : 64'd0);
			OP_NEG: y = 64'd0 - b;
			OP_NOT: y = ~b;
			OP_INC: y = b + 64'd1;
			OP_DEC: y = b - 64'd1;
			OP_ABS: y = b[63] ? 64'd0 - b : b;
			default: y = 64'd0;
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/smx_muldiv.sv -----
`timescale 1ns / 1ps
`default_nettype none

module smx_muldiv (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire smx_pkg::md_req_t  req,
	input  wire logic [63:0]       a,
	input  wire logic [63:0]       b,
	output logic                   busy,
	output logic                   done,
	output logic      [63:0]       res
);
	import smx_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic        is_mul_q;
	logic        is_mod_q;
	logic        qneg_q;
	logic        rneg_q;
	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [63:0] acc_q;
	logic [31:0] cr_q;
	logic [63:0] quo_q;
	logic [63:0] rem_q;
	logic [63:0] dvs_q;

	logic [31:0] mul_x;
	logic [31:0] mul_y;
	logic [63:0] prod;
	logic [64:0] rem_sh;
	logic [64:0] diff;
	logic        last;

	assign mul_x  = (cnt_q == 6'd2) ? a_q[63:32] : a_q[31:0];
	assign mul_y  = (cnt_q == 6'd1) ? b_q[63:32] : b_q[31:0];
	assign prod   = mul_x * mul_y;
	assign rem_sh = {rem_q, quo_q[63]};
	assign diff   = rem_sh - {1'b0, dvs_q};
	assign last   = is_mul_q ? (cnt_q == 6'd3) : (cnt_q == 6'd63);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			is_mul_q <= req.is_mul;
			is_mod_q <= req.is_mod;
			a_q      <= a;
			b_q      <= b;
			qneg_q   <= a[63] ^ b[63];
			rneg_q   <= a[63];
			quo_q    <= a[63] ? 64'd0 - a : a;
			dvs_q    <= b[63] ? 64'd0 - b : b;
			rem_q    <= '0;
		end else if (busy_q) begin
			if (is_mul_q) begin
				case (cnt_q)
					6'd0: acc_q <= prod;
					6'd1: cr_q <= prod[31:0];
					6'd2: cr_q <= cr_q + prod[31:0];
					default: acc_q[63:32] <= acc_q[63:32] + cr_q;
				endcase
			end else if (!diff[64]) begin
				rem_q <= diff[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= rem_sh[63:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (is_mul_q) begin
			res = acc_q;
		end else if (is_mod_q) begin
			res = rneg_q ? 64'd0 - rem_q : rem_q;
		end else begin
			res = qneg_q ? 64'd0 - quo_q : quo_q;
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

`default_nettype wire

// ----- rtl/smx_dmem.sv -----
`timescale 1ns / 1ps
`default_nettype none

module smx_dmem #(
	parameter int MEMORY_WORDS = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        rd_en,
	input  wire logic [7:0]  rd_byte,
	input  wire logic        wr_en,
	input  wire logic        clr_en,
	input  wire logic [7:0]  wr_byte,
	input  wire logic [63:0] wr_data,
	output logic      [63:0] rd_data
);
	localparam int AW = $clog2(MEMORY_WORDS);

	typedef logic [AW-1:0] mtab_t [256];

	function automatic mtab_t mk_tab();
		mtab_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = AW'(i % MEMORY_WORDS);
		end
		return t;
	endfunction

	localparam mtab_t MOD_TAB = mk_tab();

	logic [63:0]             mem [MEMORY_WORDS];
	logic [MEMORY_WORDS-1:0] vld_q;
	logic [63:0]             rd_q;
	logic                    rv_q;
	logic [AW-1:0]           ra;
	logic [AW-1:0]           wa;

	assign ra = MOD_TAB[rd_byte];
	assign wa = MOD_TAB[wr_byte];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wa] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rv_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wa] <= 1'b1;
			end else if (clr_en) begin
				vld_q[wa] <= 1'b0;
			end
			if (rd_en) begin
				rv_q <= vld_q[ra];
			end
		end
	end

	assign rd_data = rv_q ? rd_q : 64'd0;

endmodule

`default_nettype wire

// ----- rtl/stack_machine_execute_unit_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Executes one stack machine instruction per input word and returns one result word for it.
// The top two stack entries live in registers and the rest in a single-port stack RAM, so
// every instruction needs at most one stack read (issued when the word is accepted) and one
// write (at execute): a plain instruction is accepted and then executed. MUL runs 4
// steps on a shared 32x32 multiplier; DIV and MOD go through a radix-2 divider, one
// quotient bit a cycle. The data memory clears through per-word valid bits, so there
// is no clearing pass after reset. The result sits in an output register, so the next
// word is taken while a result waits; once a stop status is reported every later word
// repeats it.
module stack_machine_execute_unit_core #(
	parameter int STACK_ENTRIES = 256,
	parameter int MEMORY_WORDS  = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  wire logic        wr_index,
	input  wire logic [19:0] wr_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  opcode,
	input  wire logic [7:0]  operand_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [8:0]  next_pc,
	output logic      [2:0]  run_status,
	output logic      [63:0] return_value,
	output logic             print_valid,
	output logic      [63:0] print_value
);
	import smx_pkg::*;

	localparam int DW = $clog2(STACK_ENTRIES + 1);
	localparam int SW = $clog2(STACK_ENTRIES);
	localparam logic [DW-1:0] FULL = DW'(STACK_ENTRIES);

	state_t st_q, st_d;

	logic [8:0]    pl_q;
	logic [19:0]   lim_q;
	logic [DW-1:0] depth_q;
	logic [DW-1:0] rdepth_q;
	logic [8:0]    pc_q;
	logic [19:0]   step_q;
	logic          stopped_q;
	logic [2:0]    stat_q;
	logic          unit_done_q;
	logic          out_valid_q;
	logic [63:0]   tos_q;
	logic [63:0]   nos_q;

	logic [63:0]   stk_mem [STACK_ENTRIES];
	logic [8:0]    ret_mem [STACK_ENTRIES];
	logic [63:0]   stk_rd_s1;
	logic [8:0]    ret_rd_s1;
	logic [7:0]    op_s1;
	logic [7:0]    arg_s1;

	logic [8:0]    pc_o_q;
	logic [2:0]    stat_o_q;
	logic [63:0]   rv_o_q;
	logic          pv_o_q;
	logic [63:0]   pval_o_q;

	logic          acc;
	logic          out_free;
	logic          go;
	logic          fin;
	logic          unit_go;
	logic          unit_start;
	logic [63:0]   alu_y;
	logic [63:0]   dm_rd;
	logic          md_busy;
	logic          md_done;
	logic [63:0]   md_res;
	md_req_t       md_req;

	logic [63:0]   n_tos;
	logic [63:0]   n_nos;
	logic [DW-1:0] n_d;
	logic [DW-1:0] n_rd;
	logic [8:0]    npc;
	logic [2:0]    xst;
	logic          stk_we;
	logic [SW-1:0] stk_wa;
	logic [63:0]   stk_wd;
	logic          ret_we;
	logic          dm_we;
	logic          dm_clr;
	logic          pv;
	logic          do_push;
	logic          do_pop;
	logic          do_bin;
	logic [63:0]   push_val;
	logic [63:0]   bin_val;

	logic          f_stop;
	logic [2:0]    f_stat;
	logic [8:0]    f_pc;
	logic [19:0]   f_step;
	logic          f_upd;
	logic [63:0]   f_rv;

	assign acc      = in_valid && in_ready;
	assign in_ready = st_q == S_IDLE;
	assign out_free = !out_valid_q || out_ready;
	assign go       = !stopped_q && (pc_q < pl_q) && (step_q < lim_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pl_q  <= PL_RESET;
			lim_q <= LIM_RESET;
		end else if (wr_en) begin
			case (wr_index)
				CFG_PL:  pl_q <= wr_data[8:0];
				CFG_LIM: lim_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			stk_rd_s1 <= stk_mem[SW'(depth_q - DW'(3))];
			ret_rd_s1 <= ret_mem[SW'(rdepth_q - DW'(1))];
			op_s1     <= opcode;
			arg_s1    <= operand_byte;
		end
		if (fin && go && stk_we) begin
			stk_mem[stk_wa] <= stk_wd;
		end
		if (fin && go && ret_we) begin
			ret_mem[SW'(rdepth_q)] <= pc_q + 9'd2;
		end
	end

	smx_dmem #(
		.MEMORY_WORDS(MEMORY_WORDS)
	) u_dmem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (acc),
		.rd_byte (operand_byte),
		.wr_en   (fin && go && dm_we),
		.clr_en  (fin && go && dm_clr),
		.wr_byte ((op_s1 == OP_CLR) ? tos_q[7:0] : arg_s1),
		.wr_data (tos_q),
		.rd_data (dm_rd)
	);

	smx_alu u_alu (
		.op (op_s1),
		.a  (nos_q),
		.b  (tos_q),
		.y  (alu_y)
	);

	assign md_req.start  = unit_start;
	assign md_req.is_mul = op_s1 == OP_MUL;
	assign md_req.is_mod = op_s1 == OP_MOD;

	smx_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.a      (nos_q),
		.b      (tos_q),
		.busy   (md_busy),
		.done   (md_done),
		.res    (md_res)
	);

	always_comb begin
		n_tos    = tos_q;
		n_nos    = nos_q;
		n_d      = depth_q;
		n_rd     = rdepth_q;
		npc      = pc_q + 9'd1;
		xst      = ST_RUN;
		stk_we   = 1'b0;
		stk_wa   = SW'(depth_q - DW'(2));
		stk_wd   = nos_q;
		ret_we   = 1'b0;
		dm_we    = 1'b0;
		dm_clr   = 1'b0;
		pv       = 1'b0;
		do_push  = 1'b0;
		do_pop   = 1'b0;
		do_bin   = 1'b0;
		unit_go  = 1'b0;
		push_val = tos_q;
		bin_val  = unit_done_q ? md_res : alu_y;
		case (op_s1)
			OP_HALT: xst = ST_HALT;
			OP_PUSH: begin
				npc      = pc_q + 9'd2;
				do_push  = 1'b1;
				push_val = {{56{arg_s1[7]}}, arg_s1};
			end
			OP_LOAD: begin
				npc      = pc_q + 9'd2;
				do_push  = 1'b1;
				push_val = dm_rd;
			end
			OP_DUP: do_push = depth_q != '0;
			OP_OVER: begin
				do_push  = depth_q >= DW'(2);
				push_val = nos_q;
			end
			OP_POP, OP_DROP: do_pop = depth_q != '0;
			OP_SWAP: begin
				if (depth_q >= DW'(2)) begin
					n_tos = nos_q;
					n_nos = tos_q;
				end
			end
			OP_MUL: begin
				if (depth_q >= DW'(2)) begin
					unit_go = !unit_done_q;
					do_bin  = unit_done_q;
				end
			end
			OP_DIV, OP_MOD: begin
				if (depth_q >= DW'(2) && tos_q != 64'd0) begin
					unit_go = !unit_done_q;
					do_bin  = unit_done_q;
				end
			end
			OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_SHL, OP_SHR, OP_EQ, OP_NE,
			OP_LT, OP_LE, OP_GT, OP_GE, OP_CMP: do_bin = depth_q >= DW'(2);
			OP_NEG, OP_NOT, OP_INC, OP_DEC, OP_ABS: begin
				if (depth_q != '0) begin
					n_tos = alu_y;
				end
			end
			OP_JMP: npc = {1'b0, arg_s1};
			OP_JZ, OP_JNZ: begin
				npc = pc_q + 9'd2;
				if (depth_q != '0) begin
					do_pop = 1'b1;
					if ((tos_q == 64'd0) == (op_s1 == OP_JZ)) begin
						npc = {1'b0, arg_s1};
					end
				end
			end
			OP_SAVE: begin
				npc = pc_q + 9'd2;
				if (depth_q != '0) begin
					dm_we  = 1'b1;
					do_pop = 1'b1;
				end
			end
			OP_EMIT: pv = depth_q != '0;
			OP_ROT: begin
				if (depth_q >= DW'(3)) begin
					stk_we = 1'b1;
					stk_wa = SW'(depth_q - DW'(3));
					n_nos  = tos_q;
					n_tos  = stk_rd_s1;
				end
			end
			OP_NOP: ;
			OP_CALL: begin
				if (rdepth_q >= FULL) begin
					xst = ST_OVF;
				end else begin
					ret_we = 1'b1;
					n_rd   = rdepth_q + DW'(1);
					npc    = {1'b0, arg_s1};
				end
			end
			OP_RET: begin
				if (rdepth_q != '0) begin
					npc  = ret_rd_s1;
					n_rd = rdepth_q - DW'(1);
				end
			end
			OP_CLR: dm_clr = depth_q != '0;
			default: xst = ST_BAD;
		endcase
		if (do_push) begin
			if (depth_q >= FULL) begin
				xst = ST_OVF;
			end else begin
				stk_we = depth_q >= DW'(2);
				n_nos  = tos_q;
				n_tos  = push_val;
				n_d    = depth_q + DW'(1);
			end
		end
		if (do_pop || do_bin) begin
			n_tos = do_bin ? bin_val : nos_q;
			n_nos = stk_rd_s1;
			n_d   = depth_q - DW'(1);
		end
	end

	assign unit_start = (st_q == S_EXEC) && go && unit_go;
	assign fin        = (st_q == S_EXEC) && !unit_start && out_free;

	always_comb begin
		f_stop = stopped_q;
		f_stat = stat_q;
		f_pc   = pc_q;
		f_step = step_q;
		f_upd  = 1'b0;
		if (!stopped_q) begin
			if (pc_q >= pl_q) begin
				f_stop = 1'b1;
				f_stat = ST_END;
			end else if (step_q >= lim_q) begin
				f_stop = 1'b1;
				f_stat = ST_WDOG;
			end else begin
				f_upd  = 1'b1;
				f_step = step_q + 20'd1;
				f_pc   = (xst == ST_OVF) ? pc_q : npc;
				f_stat = xst;
				f_stop = xst != ST_RUN;
				if (xst == ST_RUN) begin
					if (npc >= pl_q) begin
						f_stop = 1'b1;
						f_stat = ST_END;
					end else if (f_step >= lim_q) begin
						f_stop = 1'b1;
						f_stat = ST_WDOG;
					end
				end
			end
		end
		if (f_stop && f_stat == ST_BAD) begin
			f_rv = '1;
		end else if (f_upd) begin
			f_rv = (n_d != '0) ? n_tos : 64'd0;
		end else begin
			f_rv = (depth_q != '0) ? tos_q : 64'd0;
		end
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			S_IDLE: begin
				if (acc) begin
					st_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (unit_start) begin
					st_d = S_UNIT;
				end else if (out_free) begin
					st_d = S_IDLE;
				end
			end
			S_UNIT: begin
				if (md_done) begin
					st_d = S_EXEC;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			depth_q     <= '0;
			rdepth_q    <= '0;
			pc_q        <= '0;
			step_q      <= '0;
			stopped_q   <= 1'b0;
			stat_q      <= ST_RUN;
			unit_done_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == S_UNIT && md_done) begin
				unit_done_q <= 1'b1;
			end else if (fin) begin
				unit_done_q <= 1'b0;
			end
			if (fin) begin
				out_valid_q <= 1'b1;
				pc_q        <= f_pc;
				step_q      <= f_step;
				stopped_q   <= f_stop;
				stat_q      <= f_stat;
				if (f_upd) begin
					depth_q  <= n_d;
					rdepth_q <= n_rd;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			if (f_upd) begin
				tos_q <= n_tos;
				nos_q <= n_nos;
			end
			pc_o_q   <= f_pc;
			stat_o_q <= f_stop ? f_stat : ST_RUN;
			rv_o_q   <= f_rv;
			pv_o_q   <= f_upd && pv;
			pval_o_q <= (f_upd && pv) ? tos_q : 64'd0;
		end
	end

	assign out_valid    = out_valid_q;
	assign next_pc      = pc_o_q;
	assign run_status   = stat_o_q;
	assign return_value = rv_o_q;
	assign print_valid  = pv_o_q;
	assign print_value  = pval_o_q;

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= FULL && rdepth_q <= FULL)
		else $error("stack depth beyond capacity");

	a_unit_state: assert property (@(posedge clk) disable iff (!arst_n)
		md_busy |-> st_q == S_UNIT)
		else $error("divider busy outside unit wait");

	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |=> stopped_q)
		else $error("stop status released");

endmodule

`default_nettype wire
